/* hw/rtl/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the second-chance key cache: request codes,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  // Field widths of the request and result items and of the capacity register
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned TAB_W = 7;
  localparam int unsigned ROW_W = 26;
  localparam int unsigned CAP_W = 7;

  // Divide by 100 as multiply by ceil(2^37 / 100), then shift right by 37
  localparam int unsigned       MAGIC_W      = 31;
  localparam logic [MAGIC_W-1:0] DIV100_MAGIC = 31'd1374389535;
  localparam int unsigned       DIV100_SHIFT = 37;
  localparam int unsigned       PROD_W       = VAL_W + MAGIC_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_TOUCH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WR_HIT,
    ST_WR_REF,
    ST_DIV,
    ST_EV_RD,
    ST_EV_CHK,
    ST_PUSH,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic capture;   // latch the incoming item, restart the scan
    logic scan;      // issue the next ring read and compare the last one
    logic wr_hit;    // overwrite the matched entry, clear its flag
    logic wr_ref;    // set the referenced flag of the matched entry
    logic recycle;   // move the flagged head entry to the back, flag cleared
    logic pop;       // drop the head entry (eviction)
    logic push;      // append the new entry at the back
    logic div_mul;   // start value / 100
    logic finish;    // load the result register
  } cmd_t;

  typedef struct packed {
    req_type_e req;
    logic      hit_now;
    logic      scan_end;
    logic      full;
    logic      head_ref;
    logic      out_free;
  } status_t;

endpackage

/* hw/rtl/scc_datapath.sv */
// ----------------------------------------------------------------------------
// scc_datapath
// Ring-ordered entry memory, head/count pointers, key scan, eviction moves,
// value split by 100 and the result register.
// ----------------------------------------------------------------------------
module scc_datapath #(
  parameter int unsigned CAPACITY = scc_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  req_type_i,
  input  logic [scc_pkg::KEY_W-1:0]   lookup_key_i,
  input  logic [scc_pkg::VAL_W-1:0]   stored_value_i,
  input  logic [scc_pkg::CAP_W-1:0]   cap_in_use_i,
  input  scc_pkg::cmd_t               cmd_i,
  output scc_pkg::status_t            status_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        hit_o,
  output logic [scc_pkg::TAB_W-1:0]   tab_id_o,
  output logic [scc_pkg::ROW_W-1:0]   row_id_o,
  output logic                        evicted_o
);
  import scc_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef struct packed {
    logic             referenced;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Entry storage, kept in queue order starting at head_q
  entry_t mem_q [CAPACITY];

  logic [IDX_W-1:0]  head_q, head_d, head_inc;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_addr_q;
  entry_t            rd_q;
  req_type_e         req_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic              hit_q, ev_q;
  logic [IDX_W-1:0]  found_addr_q;
  logic [VAL_W-1:0]  found_val_q;
  logic [PROD_W-1:0] prod_q;
  logic              out_valid_q;
  logic              out_hit_q, out_ev_q;
  logic [TAB_W-1:0]  out_tab_q;
  logic [ROW_W-1:0]  out_row_q;

  logic [IDX_W-1:0]  scan_addr, tail_addr, rd_addr, wr_addr;
  logic              issue, mem_we, hit_now;
  entry_t            wr_data;
  logic [CMP_W-1:0]  cap_ext, cap_max, cap_lim, cnt_ext;
  logic [ROW_W-1:0]  quot;
  logic [VAL_W-1:0]  q100, rem;
  logic              lookup_hit;

  function automatic logic [IDX_W-1:0] ring_pos(logic [IDX_W-1:0] head,
                                                logic [CNT_W-1:0] rel);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(rel);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign scan_addr = ring_pos(head_q, scan_q);
  assign tail_addr = ring_pos(head_q, count_q);
  assign head_inc  = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

  // Scan issues one read per cycle while entries remain
  assign issue   = cmd_i.scan && (scan_q < count_q);
  assign hit_now = pend_q && (rd_q.key == key_q);
  assign rd_addr = cmd_i.scan ? scan_addr : head_q;

  // Occupancy against the saturated capacity limit
  assign cap_ext = CMP_W'(cap_in_use_i);
  assign cap_max = CMP_W'(CAPACITY);
  assign cap_lim = (cap_ext > cap_max) ? cap_max : cap_ext;
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = found_addr_q;
    wr_data = '{referenced: 1'b0, key: key_q, value: val_q};
    if (cmd_i.wr_hit) begin
      mem_we = 1'b1;
    end else if (cmd_i.wr_ref) begin
      mem_we  = 1'b1;
      wr_data = '{referenced: 1'b1, key: key_q, value: found_val_q};
    end else if (cmd_i.recycle) begin
      mem_we  = 1'b1;
      wr_addr = tail_addr;
      wr_data = '{referenced: 1'b0, key: rd_q.key, value: rd_q.value};
    end else if (cmd_i.push) begin
      mem_we  = 1'b1;
      wr_addr = tail_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.recycle) begin
      head_d = head_inc;
    end else if (cmd_i.pop) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
    end else if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end
    scan_d = cmd_i.capture ? '0 : (issue ? scan_q + 1'b1 : scan_q);
    pend_d = issue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= scan_addr;
    if (cmd_i.capture) begin
      req_q <= req_type_e'(req_type_i);
      key_q <= lookup_key_i;
      val_q <= stored_value_i;
      hit_q <= 1'b0;
      ev_q  <= 1'b0;
    end else begin
      if (cmd_i.scan && hit_now) begin
        hit_q        <= 1'b1;
        found_addr_q <= pend_addr_q;
        found_val_q  <= rd_q.value;
      end
      if (cmd_i.pop) begin
        ev_q <= 1'b1;
      end
    end
    if (cmd_i.div_mul) begin
      prod_q <= PROD_W'(found_val_q) * PROD_W'(DIV100_MAGIC);
    end
  end

  // Remainder by shift-add of quotient * 100
  assign quot       = prod_q[DIV100_SHIFT +: ROW_W];
  assign q100       = (VAL_W'(quot) << 6) + (VAL_W'(quot) << 5) + (VAL_W'(quot) << 2);
  assign rem        = found_val_q - q100;
  assign lookup_hit = hit_q && (req_q == REQ_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_hit_q <= hit_q;
      out_ev_q  <= ev_q;
      out_tab_q <= lookup_hit ? rem[TAB_W-1:0] : '0;
      out_row_q <= lookup_hit ? quot : '0;
    end
  end

  assign status_o = '{
    req:      req_q,
    hit_now:  hit_now,
    scan_end: !pend_q && !(scan_q < count_q),
    full:     (count_q != '0) && (cnt_ext >= cap_lim),
    head_ref: rd_q.referenced,
    out_free: !out_valid_q || out_ready_i
  };

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign tab_id_o    = out_tab_q;
  assign row_id_o    = out_row_q;
  assign evicted_o   = out_ev_q;

endmodule

/* hw/rtl/scc_controller.sv */
// ----------------------------------------------------------------------------
// scc_controller
// Sequences one item: key scan, in-place update, eviction walk, append,
// value split and result hand-off.
// ----------------------------------------------------------------------------
module scc_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             eviction_mode_i,
  input  scc_pkg::status_t status_i,
  output scc_pkg::cmd_t    cmd_o
);
  import scc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.req == REQ_NONE) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan = 1'b1;
          if (status_i.hit_now) begin
            unique case (status_i.req)
              REQ_INSERT: state_d = ST_WR_HIT;
              REQ_LOOKUP: state_d = ST_DIV;
              REQ_TOUCH:  state_d = ST_WR_REF;
              default:    state_d = ST_FINISH;
            endcase
          end else if (status_i.scan_end) begin
            if (status_i.req != REQ_INSERT) begin
              state_d = ST_FINISH;
            end else if (!status_i.full) begin
              state_d = ST_PUSH;
            end else if (eviction_mode_i) begin
              state_d = ST_EV_RD;
            end else begin
              // plain FIFO: drop the oldest entry right away
              cmd_o.pop = 1'b1;
              state_d   = ST_PUSH;
            end
          end
        end
      end
      ST_WR_HIT: begin
        cmd_o.wr_hit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_WR_REF: begin
        cmd_o.wr_ref = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_DIV: begin
        cmd_o.div_mul = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_EV_RD: begin
        state_d = ST_EV_CHK;
      end
      ST_EV_CHK: begin
        if (status_i.head_ref) begin
          cmd_o.recycle = 1'b1;
          state_d       = ST_EV_RD;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/second_chance_key_cache.sv */
// ----------------------------------------------------------------------------
// second_chance_key_cache
// Fully associative key-to-value cache with FIFO or second-chance eviction,
// configured over an APB-style register port.
// ----------------------------------------------------------------------------
// Sequence, accept to out_valid_o: key scan over the held entries, then on a hit an update
//   or value split, on an insert miss an append of the new key (after a second-chance
//   eviction walk that moves flagged entries back, when full), then the result load; an
//   unknown request skips the scan and goes straight to the result load.
// Throughput: one item at a time; the next is accepted in the idle cycle after the result
//   is loaded, while that result may still wait. Reset: queue empty, mode 1, capacity 64.
module second_chance_key_cache #(
  parameter int unsigned CAPACITY = scc_pkg::DEF_CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                req_type_i,
  input  logic [scc_pkg::KEY_W-1:0] lookup_key_i,
  input  logic [scc_pkg::VAL_W-1:0] stored_value_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic [scc_pkg::TAB_W-1:0] tab_id_o,
  output logic [scc_pkg::ROW_W-1:0] row_id_o,
  output logic                      evicted_o,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import scc_pkg::*;

  // Register index is the word address
  localparam logic REG_EVICTION_MODE   = 1'b0;
  localparam logic REG_CAPACITY_IN_USE = 1'b1;

  logic             mode_q;
  logic [CAP_W-1:0] cap_q;
  logic             reg_idx;
  logic             reg_wr;
  cmd_t             cmd;
  status_t          status;

  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write in the access phase; only paddr[2] is decoded, so other addresses alias onto the two registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      cap_q  <= CAP_W'(64);
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_EVICTION_MODE:   mode_q <= pwdata[0];
        REG_CAPACITY_IN_USE: cap_q  <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EVICTION_MODE:   prdata = {31'b0, mode_q};
      REG_CAPACITY_IN_USE: prdata = {{(32 - CAP_W){1'b0}}, cap_q};
      default:             prdata = '0;
    endcase
  end

  // Controller: decides what the datapath does each cycle
  scc_controller u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .eviction_mode_i (mode_q),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // Datapath: entry ring, scan compare, divide by 100, result register
  scc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .lookup_key_i   (lookup_key_i),
    .stored_value_i (stored_value_i),
    .cap_in_use_i   (cap_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .hit_o          (hit_o),
    .tab_id_o       (tab_id_o),
    .row_id_o       (row_id_o),
    .evicted_o      (evicted_o)
  );

endmodule

/* hw/rtl/scc_checker.sv */
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks of the key cache: one item in flight, result held while
// stalled, and consistency of the result fields.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      hit_o,
  input logic [scc_pkg::TAB_W-1:0] tab_id_o,
  input logic [scc_pkg::ROW_W-1:0] row_id_o,
  input logic                      evicted_o
);
  import scc_pkg::*;

  // Hold the request side closed right after an item is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(evicted_o)
      && $stable(tab_id_o) && $stable(row_id_o))
    else $error("stalled result changed or dropped");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o)
    else $error("eviction reported on a hit");

  a_split_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> (tab_id_o == '0) && (row_id_o == '0))
    else $error("value fields set without a hit");

  a_table_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tab_id_o < TAB_W'(100))
    else $error("tab_id out of range");

endmodule

bind second_chance_key_cache scc_checker u_scc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_o       (hit_o),
  .tab_id_o    (tab_id_o),
  .row_id_o    (row_id_o),
  .evicted_o   (evicted_o)
);
